### rtl/rgb565_palette_allocator_defines.svh
// ----------------------------------------------------------------------------
// rgb565 palette allocator assertion macros
// concurrent check helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RGB565_PALETTE_ALLOCATOR_DEFINES_SVH
`define RGB565_PALETTE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RGBPA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbpa assertion failed");

// next-cycle implication
`define RGBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbpa assertion failed");

`else

`define RGBPA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RGBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/rgbpa_pkg.sv
// ----------------------------------------------------------------------------
// rgbpa_pkg
// shared types, constants and tables of the rgb565 palette allocator
// ----------------------------------------------------------------------------
package rgbpa_pkg;

  localparam int PAL_SIZE     = 256;
  localparam int ADDR_W       = $clog2(PAL_SIZE);
  localparam int IDX_W        = 8;
  localparam int COLOR_W      = 16;
  localparam int NUM_DEFAULTS = 16;
  localparam int DEF_W        = 4;

  localparam logic [ADDR_W-1:0] LAST_IDX      = ADDR_W'(PAL_SIZE - 1);
  localparam logic [ADDR_W-1:0] DEFAULT_COUNT = ADDR_W'(NUM_DEFAULTS);

  localparam logic [1:0] PASS_EXACT = 2'd0;
  localparam logic [1:0] PASS_LAST  = 2'd3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  // low red, green and blue bits dropped by the near-match passes
  localparam logic [COLOR_W-1:0] IGNORE_1 = 16'h0861;
  localparam logic [COLOR_W-1:0] IGNORE_2 = 16'h18E3;
  localparam logic [COLOR_W-1:0] IGNORE_3 = 16'h39E7;

  typedef enum logic [2:0] {
    OUT_HIT       = 3'd0,
    OUT_APPEND    = 3'd1,
    OUT_NEAR      = 3'd2,
    OUT_OVERWRITE = 3'd3,
    OUT_RESET     = 3'd4
  } outcome_t;

  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] color;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] palette_index;
    outcome_t         outcome;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } wr_req_t;

  function automatic logic [COLOR_W-1:0] default_color(input logic [DEF_W-1:0] i);
    logic [COLOR_W-1:0] c;
    unique case (i)
      4'd0:  c = 16'h0000;
      4'd1:  c = 16'h000F;
      4'd2:  c = 16'h03E0;
      4'd3:  c = 16'h03EF;
      4'd4:  c = 16'h7800;
      4'd5:  c = 16'h780F;
      4'd6:  c = 16'h7BE0;
      4'd7:  c = 16'hC618;
      4'd8:  c = 16'h7BEF;
      4'd9:  c = 16'h001F;
      4'd10: c = 16'h07E0;
      4'd11: c = 16'h07FF;
      4'd12: c = 16'hF800;
      4'd13: c = 16'hF81F;
      4'd14: c = 16'hFFE0;
      4'd15: c = 16'hFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] keep_mask(input logic [1:0] pass);
    logic [COLOR_W-1:0] m;
    unique case (pass)
      2'd0: m = '1;
      2'd1: m = ~IGNORE_1;
      2'd2: m = ~IGNORE_2;
      2'd3: m = ~IGNORE_3;
    endcase
    return m;
  endfunction

endpackage

### rtl/rgb565_palette_allocator.sv
// ----------------------------------------------------------------------------
// rgb565_palette_allocator
// palette lookup and allocation of rgb565 colors with near-match fallback
// ----------------------------------------------------------------------------
// One transaction at a time. A reset command hands its result through the
// result register to the response register. A lookup scans the palette
// with a single comparator fed by the one read port of the palette memory,
// one entry per cycle, in passes (0 exact, 1..3 near): an exact miss appends
// while there is room, and when all four passes miss on a full palette the
// spare last entry is overwritten. The request side stalls while a lookup is
// running; a finished result sits in the response register until taken.
// Entries 0..15 hold the fixed default colors and are never written, so a
// reset command only rewinds the entry count and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "rgb565_palette_allocator_defines.svh"

module rgb565_palette_allocator import rgbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // sequencer state
  state_t             state, state_next;
  logic [ADDR_W-1:0]  count, count_next;     // entries in use
  logic [1:0]         pass, pass_next;       // 0 exact, 1..3 near passes
  logic [ADDR_W-1:0]  iss, iss_next;         // next address to read
  logic               cmp_valid, cmp_valid_next;
  logic [ADDR_W-1:0]  cmp_idx, cmp_idx_next; // entry whose data is at the compare
  logic [COLOR_W-1:0] key, key_next;         // color under lookup
  rsp_t               res, res_next;         // result waiting for the response register
  logic               rsp_valid_next;
  rsp_t               rsp_next;

  rd_req_t            rd;
  wr_req_t            wr;
  logic [COLOR_W-1:0] rd_data;
  logic               cmp_hit;
  logic [ADDR_W-1:0]  count_last;

  rgbpa_store u_store (
    .clk     (clk),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // the shared comparator: masked equality against the entry just read
  assign cmp_hit    = ((rd_data ^ key) & keep_mask(pass)) == '0;
  assign count_last = count - ADDR_W'(1);

  // new work only enters from idle
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    pass_next      = pass;
    iss_next       = iss;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    key_next       = key;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    rd             = '0;
    wr             = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_RESET) begin
            // defaults are fixed, only the count rewinds
            count_next             = DEFAULT_COUNT;
            res_next.palette_index = '0;
            res_next.outcome       = OUT_RESET;
            state_next             = S_FIN;
          end else begin
            key_next       = req.color;
            pass_next      = PASS_EXACT;
            iss_next       = '0;
            cmp_valid_next = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read side: one entry per cycle until the count is reached
        if (iss < count) begin
          rd.en          = 1'b1;
          rd.addr        = iss;
          iss_next       = iss + ADDR_W'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = iss;
        end else begin
          cmp_valid_next = 1'b0;
        end

        // compare side: sees the entry in the cycle after its read was issued
        if (cmp_valid) begin
          if (cmp_hit) begin
            res_next.palette_index = IDX_W'(cmp_idx);
            res_next.outcome       = (pass == PASS_EXACT) ? OUT_HIT : OUT_NEAR;
            state_next             = S_FIN;
          end else if (cmp_idx == count_last) begin
            if (pass == PASS_EXACT && count < LAST_IDX) begin
              // room left: append at the end
              wr.en                  = 1'b1;
              wr.addr                = count;
              wr.data                = key;
              res_next.palette_index = IDX_W'(count);
              res_next.outcome       = OUT_APPEND;
              count_next             = count + ADDR_W'(1);
              state_next             = S_FIN;
            end else if (pass == PASS_LAST) begin
              // nothing close enough: replace the spare last entry
              wr.en                  = 1'b1;
              wr.addr                = count;
              wr.data                = key;
              res_next.palette_index = IDX_W'(count);
              res_next.outcome       = OUT_OVERWRITE;
              state_next             = S_FIN;
            end else begin
              // widen the mask and rescan
              pass_next      = pass + 2'd1;
              iss_next       = '0;
              cmp_valid_next = 1'b0;
            end
          end
        end
      end

      S_FIN: begin
        // hand over once the response register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pass    <= pass_next;
    iss     <= iss_next;
    cmp_idx <= cmp_idx_next;
    key     <= key_next;
    res     <= res_next;
    rsp     <= rsp_next;
    if (rst) begin
      state     <= S_IDLE;
      count     <= DEFAULT_COUNT;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // entry count never leaves the default..last range
  `RGBPA_ASSERT_NOW(a_count_range, clk, rst, 1'b1, (count >= DEFAULT_COUNT) && (count <= LAST_IDX))

  // a reset command rewinds the count on the next cycle
  `RGBPA_ASSERT_NEXT(a_reset_cmd, clk, rst, req_valid && !req_stall && req.cmd == CMD_RESET, count == DEFAULT_COUNT)

  // the compare stage only ever sees entries in use
  `RGBPA_ASSERT_NOW(a_cmp_in_range, clk, rst, state == S_SCAN && cmp_valid, cmp_idx < count)

endmodule

### rtl/rgbpa_store.sv
// ----------------------------------------------------------------------------
// rgbpa_store
// palette storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module rgbpa_store import rgbpa_pkg::*; (
  input  logic               clk,
  input  rd_req_t            rd,
  input  wr_req_t            wr,
  output logic [COLOR_W-1:0] rd_data
);

  // the first entries are never written, they always read the fixed defaults
  logic [COLOR_W-1:0] mem [PAL_SIZE];
  logic [COLOR_W-1:0] mem_q;
  logic [COLOR_W-1:0] def_q;
  logic               def_sel;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      mem_q   <= mem[rd.addr];
      def_q   <= default_color(rd.addr[DEF_W-1:0]);
      def_sel <= (rd.addr < DEFAULT_COUNT);
    end
  end

  assign rd_data = def_sel ? def_q : mem_q;

endmodule
